/* rtl/wwasmd_pkg.sv */
// Package for the 256-bit add/subtract/multiply/divide unit.
// Holds payload structs, operation codes and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package wwasmd_pkg;

   localparam int LIMB_BITS = 64;
   localparam int WORD_BITS = 256;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] top_limb_0;
      logic [63:0] top_limb_1;
      logic [63:0] top_limb_2;
      logic [63:0] top_limb_3;
      logic [63:0] next_limb_0;
      logic [63:0] next_limb_1;
      logic [63:0] next_limb_2;
      logic [63:0] next_limb_3;
   } req_type;

   typedef struct packed {
      logic [63:0] result_limb_0;
      logic [63:0] result_limb_1;
      logic [63:0] result_limb_2;
      logic [63:0] result_limb_3;
      logic        divide_by_zero;
   } rsp_type;

   // Classified work item handed from the front end to the back end.
   typedef struct packed {
      op_type         op;
      logic           done;   // result already known (add, subtract, zero divide)
      logic [255:0]   a;      // result when done, else top operand
      logic [255:0]   b;
      logic           dz;
   } job_type;

endpackage

/* rtl/wide_word_add_sub_mul_div.sv */
// 256-bit add/subtract/multiply/divide unit, top level.
// Add, subtract and zero divide settle in the front end; multiply and divide
// use the single 32x32 multiplier and one-bit-per-cycle divider in the back
// end, which takes no new job until its result is taken. Add/subtract pass
// one beat per cycle while results are taken. Reset clears all control.
// Depends on wwasmd_pkg, wwasmd_front, wwasmd_queue, wwasmd_back.
`timescale 1ns / 1ps
module wide_word_add_sub_mul_div #(
   parameter int QUEUE_DEPTH = wwasmd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wwasmd_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wwasmd_pkg::rsp_type  rsp_data
);

   logic                f_valid, f_ready, q_valid, q_ready;
   wwasmd_pkg::job_type f_job, q_job;

   wwasmd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .job_valid(f_valid), .job_ready(f_ready), .job_data(f_job)
   );

   wwasmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_job)
   );

   wwasmd_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job_data(q_job),
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

/* rtl/wwasmd_front.sv */
// Front end: accepts request beats, does add/subtract/zero-divide at once.
// Depends on wwasmd_pkg.
`timescale 1ns / 1ps
module wwasmd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wwasmd_pkg::req_type  req_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output wwasmd_pkg::job_type  job_data
);

   wwasmd_pkg::job_type job_ff, job_in;
   logic                valid_ff;
   logic [255:0]        top_w, nxt_w;

   assign top_w = {req_data.top_limb_3, req_data.top_limb_2,
                   req_data.top_limb_1, req_data.top_limb_0};
   assign nxt_w = {req_data.next_limb_3, req_data.next_limb_2,
                   req_data.next_limb_1, req_data.next_limb_0};

   assign req_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job_data  = job_ff;

   // Classify the operation and settle the quick ones here.
   always_comb begin
      job_in.op   = wwasmd_pkg::op_type'(req_data.kind);
      job_in.done = 1'b0;
      job_in.a    = top_w;
      job_in.b    = nxt_w;
      job_in.dz   = 1'b0;
      unique case (wwasmd_pkg::op_type'(req_data.kind))
         wwasmd_pkg::OP_ADD: begin
            job_in.done = 1'b1;
            job_in.a    = top_w + nxt_w;
         end
         wwasmd_pkg::OP_SUB: begin
            job_in.done = 1'b1;
            job_in.a    = top_w - nxt_w;
         end
         wwasmd_pkg::OP_MUL: begin
         end
         wwasmd_pkg::OP_DIV: begin
            if (nxt_w == '0) begin
               job_in.done = 1'b1;
               job_in.a    = '0;
               job_in.dz   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         job_ff <= job_in;
      end
   end

endmodule

/* rtl/wwasmd_queue.sv */
// Short queue between front and back end.
// Depends on wwasmd_pkg.
`timescale 1ns / 1ps
module wwasmd_queue #(
   parameter int DEPTH = wwasmd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  wwasmd_pkg::job_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output wwasmd_pkg::job_type out_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   wwasmd_pkg::job_type  slot_ff [DEPTH];
   logic [AW-1:0]        wr_ff, rd_ff;
   logic [AW:0]          count_ff;
   logic                 push, pop;

   assign in_ready  = (count_ff != (AW+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |=> count_ff <= (AW+1)'(DEPTH)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("pop from empty queue");
`endif

endmodule

/* rtl/wwasmd_back.sv */
// Back end: multiplies a 32-bit half-limb pair per cycle and divides one bit per cycle.
// Depends on wwasmd_pkg.
`timescale 1ns / 1ps
module wwasmd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  wwasmd_pkg::job_type  job_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wwasmd_pkg::rsp_type  rsp_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} st_type;

   st_type        state_ff, state_in;
   logic [255:0]  a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [255:0]  rem_ff, rem_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic          dz_ff, dz_in;
   logic [2:0]    i_ff, i_in, j_ff, j_in;
   logic [31:0]   a_half, b_half;
   logic [3:0]    pos;
   logic [63:0]   prod;
   logic [256:0]  sh, diff;
   logic [255:0]  addend;

   // One 32x32 partial product a[i]*b[j] of 32-bit halves, placed at half i+j.
   assign a_half = a_ff[32*i_ff +: 32];
   assign b_half = b_ff[32*j_ff +: 32];
   assign pos    = 4'(i_ff) + 4'(j_ff);
   assign prod   = {32'b0, a_half} * {32'b0, b_half};
   assign addend = 256'(prod) << {pos, 5'd0};
   assign sh     = {rem_ff, a_ff[255]};
   assign diff   = sh - {1'b0, b_ff};

   assign job_ready = (state_ff == ST_IDLE) || (state_ff == ST_OUT && rsp_ready);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = {acc_ff[63:0], acc_ff[127:64], acc_ff[191:128],
                       acc_ff[255:192], dz_ff};

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; dz_in = dz_ff; i_in = i_ff; j_in = j_ff;
      unique case (state_ff)
         ST_MUL: begin
            acc_in = acc_ff + addend;
            if (pos == 4'd7) begin
               if (i_ff == 3'd7) begin
                  state_in = ST_OUT;
               end else begin
                  i_in = i_ff + 3'd1;
                  j_in = 3'd0;
               end
            end else begin
               j_in = j_ff + 3'd1;
            end
         end
         ST_DIV: begin
            // Shift in one dividend bit, subtract when at least the divisor.
            a_in = {a_ff[254:0], 1'b0};
            if (sh[256] || !diff[256]) begin
               rem_in = diff[255:0];
               acc_in = {acc_ff[254:0], 1'b1};
            end else begin
               rem_in = sh[255:0];
               acc_in = {acc_ff[254:0], 1'b0};
            end
            cnt_in = cnt_ff - 8'd1;
            if (cnt_ff == 8'd0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
         end
         default: begin
         end
      endcase
      // Take a new job whenever the result register is free.
      if (job_ready && job_valid) begin
         a_in = job_data.a; b_in = job_data.b; dz_in = job_data.dz;
         rem_in = '0; cnt_in = 8'd255; i_in = '0; j_in = '0;
         if (job_data.done) begin
            acc_in = job_data.a;
            state_in = ST_OUT;
         end else if (job_data.op == wwasmd_pkg::OP_MUL) begin
            acc_in = '0;
            state_in = ST_MUL;
         end else begin
            acc_in = '0;
            state_in = ST_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; dz_ff <= dz_in; i_ff <= i_in; j_ff <= j_in;
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dz_ff |-> acc_ff == '0) else $error("zero divide result");
   a_mul_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> pos <= 4'd7) else $error("bad limb pair");
`endif

endmodule

/* tb/wwasmd_checker.sv */
// Checker for the 256-bit add/subtract/multiply/divide unit.
// Watches both channels, predicts each result and compares field by field.
// Depends on wwasmd_pkg.
`timescale 1ns / 1ps
module wwasmd_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  wwasmd_pkg::req_type  req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wwasmd_pkg::rsp_type  rsp_data,
   output int                   fail_count,
   output int                   pending_count
);
   import wwasmd_pkg::*;

   rsp_type expected_results[$];

   // Unsigned restoring division with the 257th remainder bit kept.
   function automatic logic [255:0] quotient_of(logic [255:0] n, logic [255:0] d);
      logic [256:0] rem;
      logic [255:0] q;
      rem = '0;
      q = '0;
      for (int bit_idx = 255; bit_idx >= 0; bit_idx--) begin
         rem = {rem[255:0], n[bit_idx]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[bit_idx] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic rsp_type compute_result(req_type r);
      logic [255:0] top_word;
      logic [255:0] next_word;
      logic [255:0] sum;
      rsp_type res;
      top_word = {r.top_limb_3, r.top_limb_2, r.top_limb_1, r.top_limb_0};
      next_word = {r.next_limb_3, r.next_limb_2, r.next_limb_1, r.next_limb_0};
      res.divide_by_zero = 1'b0;
      case (op_type'(r.kind))
         OP_ADD: sum = top_word + next_word;
         OP_SUB: sum = top_word - next_word;
         OP_MUL: sum = top_word * next_word;
         default: begin
            if (next_word == '0) begin
               sum = '0;
               res.divide_by_zero = 1'b1;
            end else begin
               sum = quotient_of(top_word, next_word);
            end
         end
      endcase
      {res.result_limb_3, res.result_limb_2, res.result_limb_1, res.result_limb_0} = sum;
      return res;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on each accepted request beat, compare on each result beat.
   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(compute_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: %p", rsp_data);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (want.result_limb_0 !== rsp_data.result_limb_0) begin
                  $error("result_limb_0 exp %h got %h", want.result_limb_0,
                         rsp_data.result_limb_0);
                  errs++;
               end
               if (want.result_limb_1 !== rsp_data.result_limb_1) begin
                  $error("result_limb_1 exp %h got %h", want.result_limb_1,
                         rsp_data.result_limb_1);
                  errs++;
               end
               if (want.result_limb_2 !== rsp_data.result_limb_2) begin
                  $error("result_limb_2 exp %h got %h", want.result_limb_2,
                         rsp_data.result_limb_2);
                  errs++;
               end
               if (want.result_limb_3 !== rsp_data.result_limb_3) begin
                  $error("result_limb_3 exp %h got %h", want.result_limb_3,
                         rsp_data.result_limb_3);
                  errs++;
               end
               if (want.divide_by_zero !== rsp_data.divide_by_zero) begin
                  $error("divide_by_zero exp %b got %b", want.divide_by_zero,
                         rsp_data.divide_by_zero);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

/* tb/tb.sv */
// Testbench top for the 256-bit add/subtract/multiply/divide unit.
// Drives directed and random operations with random idling and stalls.
// Depends on wwasmd_pkg, wide_word_add_sub_mul_div and wwasmd_checker.
`timescale 1ns / 1ps
module tb;
   import wwasmd_pkg::*;

   localparam int RANDOM_ITEMS = 430;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      quiet_phase = 1'b0;
   bit      long_hold = 1'b0;

   wide_word_add_sub_mul_div u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   wwasmd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] rand_limb();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         3: return {32'h0, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic logic [255:0] rand_word();
      logic [255:0] w;
      w = {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
      // Short words make quotients and carries interesting.
      if ($urandom_range(0, 3) == 0)
         w = w >> $urandom_range(0, 255);
      return w;
   endfunction

   // Offer one request beat and hold it until accepted.
   task automatic send_op(op_type op, logic [255:0] top_word, logic [255:0] next_word);
      req_type r;
      r.kind = op;
      {r.top_limb_3, r.top_limb_2, r.top_limb_1, r.top_limb_0} = top_word;
      {r.next_limb_3, r.next_limb_2, r.next_limb_1, r.next_limb_0} = next_word;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Result side: random stall bursts, one long hold while requests pile up.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      logic [255:0] ones;
      logic [255:0] a;
      logic [255:0] b;
      int           wait_cycles;
      ones = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, wraps, zero divide and large remainders.
      send_op(OP_ADD, ones, 256'd1);
      send_op(OP_ADD, ones, ones);
      send_op(OP_ADD, '0, '0);
      send_op(OP_ADD, {192'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 256'd1);
      send_op(OP_SUB, '0, 256'd1);
      send_op(OP_SUB, ones, ones);
      send_op(OP_SUB, 256'h1 << 64, 256'd1);
      send_op(OP_MUL, ones, ones);
      send_op(OP_MUL, 256'h1 << 128, 256'h1 << 128);
      send_op(OP_MUL, {192'h0, 64'hFFFF_FFFF_FFFF_FFFF}, {192'h0, 64'hFFFF_FFFF_FFFF_FFFF});
      send_op(OP_MUL, ones, '0);
      send_op(OP_DIV, ones, '0);
      send_op(OP_DIV, '0, '0);
      send_op(OP_DIV, ones, 256'd1);
      send_op(OP_DIV, ones, ones);
      send_op(OP_DIV, ones, 256'h1 << 255);
      send_op(OP_DIV, ones, (256'h1 << 255) | 256'd1);
      send_op(OP_DIV, 256'd5, 256'd7);
      send_op(OP_DIV, '0, 256'd3);
      send_op(OP_DIV, ones - 256'd1, ones);

      // Pile up requests behind a held result channel.
      long_hold = 1'b1;
      repeat (8) send_op(op_type'($urandom_range(0, 1)), rand_word(), rand_word());

      // Random: add and subtract weighted heavily since divides are slow.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 60) quiet_phase = 1'b1;
         a = rand_word();
         b = rand_word();
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_op(OP_ADD, a, b);
            4, 5, 6:    send_op(OP_SUB, a, b);
            7, 8:       send_op(OP_MUL, a, b);
            default:    send_op(OP_DIV, a, ($urandom_range(0, 7) == 0) ? '0 : b);
         endcase
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while ((pending_count != 0 || long_hold) && wait_cycles < 400_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
